// ===== rtl/core/sorted_timer_queue_defines.svh =====
// Assertion macros for the timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Property checked at every rising clock edge outside reset.
`define STQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Property checked at every rising clock edge, reset included.
`define STQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STQ_ASSERT(label, clk, rstn, prop, msg)
`define STQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/stq_pkg.sv =====
// Types, codes and defaults shared by the sorted timer queue.
`default_nettype none

package stq_pkg;

    localparam int STQ_DEPTH_DEF = 64;
    localparam int DL_W          = 32;
    localparam int ID_W          = 32;
    localparam int TAG_W         = 32;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_CANCEL   = 2'd1;
    localparam logic [1:0] CMD_FIRE     = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } stq_entry_t;

    // Strobes from the sequencer to every cell.
    typedef struct packed {
        logic cmp;   // register compare flags against the item just accepted
        logic ins;   // open a slot and insert the new entry
        logic rem;   // close the gap at the first hit and beyond
    } stq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/stq_cell.sv =====
// One slot of the sorted chain: holds an entry and moves it to or from a neighbour.
`default_nettype none

module stq_cell
    import stq_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire              aclk,
    input  wire  stq_ctl_t   ctl,
    input  wire  [CNT_W-1:0] count,
    input  wire  [DL_W-1:0]  cmp_deadline,
    input  wire  [ID_W-1:0]  cmp_id,
    input  wire  stq_entry_t new_ent,
    input  wire  stq_entry_t left_ent,
    input  wire              left_gt,
    input  wire  stq_entry_t right_ent,
    input  wire              rm_in,
    output logic             rm_out,
    output logic             gt_out,
    output stq_entry_t       ent_out
);

    stq_entry_t ent_reg;
    stq_entry_t ent_next;
    logic       gt_reg;
    logic       match_reg;
    logic       occupied;

    assign occupied = (count > CNT_W'(IDX));
    assign rm_out   = rm_in | match_reg;
    assign gt_out   = gt_reg;
    assign ent_out  = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (ctl.ins && gt_reg) begin
            // The left neighbour moves up too, unless this slot is where the new entry lands.
            ent_next = left_gt ? left_ent : new_ent;
        end else if (ctl.rem && rm_out) begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        if (ctl.cmp) begin
            gt_reg    <= !occupied || (ent_reg.deadline > cmp_deadline);
            match_reg <= occupied && (ent_reg.id == cmp_id);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: item handshakes, sequencer and the chain of cells.
//
// Input items arrive on the s_ channel: s_tuser carries the command (schedule, cancel, fire)
// and s_tdata the deadline, user tag and cancel id. Every item yields exactly one result
// item on the m_ channel, with the status and fired flag in m_tuser and the timer id,
// fired deadline and fired tag in m_tdata.
// Entries sit in a row of cells ordered by deadline. In the cycle an item is accepted each
// cell registers its compare against the new deadline or cancel id; in the next cycle all
// cells shift together to open or close a slot and the result is loaded into the output
// register, and m_tvalid rises once that register holds it. No new item is taken while a
// command executes. The cancel search is an OR chain rippling through the cells, which
// sets the longest path of the shift cycle.
// A held result blocks a new item only until it is taken: s_tready rises again in the cycle
// that m_tready takes the waiting result. Reset empties the queue and restarts the id counter
// at zero; no clearing pass is needed.
`default_nettype none

`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = STQ_DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [95:0] s_tdata,   // deadline [31:0], user_tag [63:32], cancel_id [95:64]
    input  wire  [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata,   // timer_id [31:0], fired_deadline [63:32], fired_tag [95:64]
    output logic [2:0]  m_tuser    // status [1:0], fired [2]
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_W-1:0]    id_ctr_reg, id_ctr_next;
    logic [1:0]         cmd_reg;
    logic [DL_W-1:0]    dl_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [ID_W-1:0]    cid_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [95:0]        m_tdata_reg, m_tdata_next;
    logic [2:0]         m_tuser_reg, m_tuser_next;

    logic               accept;
    logic               full;
    logic               found;
    stq_ctl_t           ctl;
    stq_entry_t         new_ent;
    stq_entry_t         ent_w [QUEUE_DEPTH];
    logic               gt_w  [QUEUE_DEPTH];
    logic               rm_w  [QUEUE_DEPTH+1];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign new_ent.deadline = dl_reg;
    assign new_ent.id       = id_ctr_reg;
    assign new_ent.tag      = tag_reg;

    assign ctl.cmp = accept;
    assign ctl.ins = (state_reg == ST_EXEC) && (cmd_reg == CMD_SCHEDULE) && !full;
    assign ctl.rem = (state_reg == ST_EXEC) && ((cmd_reg == CMD_CANCEL) || (cmd_reg == CMD_FIRE));

    // A fire removes the head, so every cell closes up; a cancel closes from its first hit.
    assign rm_w[0] = (cmd_reg == CMD_FIRE);
    assign found   = rm_w[QUEUE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            stq_entry_t left_ent;
            stq_entry_t right_ent;
            logic       left_gt;

            if (g == 0) begin : g_head
                assign left_ent = new_ent;
                assign left_gt  = 1'b0;
            end else begin : g_body
                assign left_ent = ent_w[g-1];
                assign left_gt  = gt_w[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign right_ent = '0;
            end else begin : g_inner
                assign right_ent = ent_w[g+1];
            end

            stq_cell #(
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .aclk         (aclk),
                .ctl          (ctl),
                .count        (count_reg),
                .cmp_deadline (s_tdata[31:0]),
                .cmp_id       (s_tdata[95:64]),
                .new_ent      (new_ent),
                .left_ent     (left_ent),
                .left_gt      (left_gt),
                .right_ent    (right_ent),
                .rm_in        (rm_w[g]),
                .rm_out       (rm_w[g+1]),
                .gt_out       (gt_w[g]),
                .ent_out      (ent_w[g])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        id_ctr_next   = id_ctr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next    = ST_IDLE;
                m_tvalid_next = 1'b1;
                m_tdata_next  = '0;
                m_tuser_next  = {1'b0, STATUS_OK};
                case (cmd_reg)
                    CMD_SCHEDULE: begin
                        if (full) begin
                            m_tuser_next = {1'b0, STATUS_FULL};
                        end else begin
                            m_tdata_next[31:0] = id_ctr_reg;
                            count_next         = count_reg + 1'b1;
                            id_ctr_next        = id_ctr_reg + 1'b1;
                        end
                    end
                    CMD_CANCEL: begin
                        m_tdata_next[31:0] = cid_reg;
                        if (found) begin
                            count_next = count_reg - 1'b1;
                        end else begin
                            m_tuser_next = {1'b0, STATUS_NOT_FOUND};
                        end
                    end
                    CMD_FIRE: begin
                        if (count_reg == '0) begin
                            m_tuser_next = {1'b0, STATUS_EMPTY};
                        end else begin
                            m_tdata_next = {ent_w[0].tag, ent_w[0].deadline, ent_w[0].id};
                            m_tuser_next = {1'b1, STATUS_OK};
                            count_next   = count_reg - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            id_ctr_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            id_ctr_reg   <= id_ctr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (accept) begin
            cmd_reg <= s_tuser;
            dl_reg  <= s_tdata[31:0];
            tag_reg <= s_tdata[63:32];
            cid_reg <= s_tdata[95:64];
        end
    end

    `STQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count exceeds depth")
    `STQ_ASSERT(a_exec_result, aclk, aresetn, state_reg == ST_EXEC |=> m_tvalid_reg, "no result after a command")
    `STQ_ASSERT(a_fire_pops, aclk, aresetn, (state_reg == ST_EXEC && cmd_reg == CMD_FIRE && count_reg != '0) |=> (count_reg + 1'b1 == $past(count_reg)), "fire did not pop")
    `STQ_ASSERT(a_no_accept_in_exec, aclk, aresetn, state_reg == ST_EXEC |-> !s_tready, "item taken while a command executes")
    `STQ_ASSERT(a_sched_id_step, aclk, aresetn, (state_reg == ST_EXEC && cmd_reg == CMD_SCHEDULE && !full) |=> (id_ctr_reg == $past(id_ctr_reg) + 1'b1), "id counter did not advance")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the sorted timer queue: directed commands, then random phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    localparam int DEPTH = STQ_DEPTH_DEF;
    localparam int ITEM_TARGET = 1200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PERCENT = 35;
    localparam int DRAIN_CYCLES = 8;
    // The block defines no code for the fourth command value; it must do nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} stim_phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] timer_id;
        logic [31:0] fired_deadline;
        logic [31:0] fired_tag;
        logic        fired;
    } timer_result_t;

    class timer_scoreboard;
        stq_entry_t    timers[$];   // live timers in deadline order
        logic [31:0]   next_id;
        timer_result_t awaited[$];
        int            errors;

        function new();
            next_id = '0;
            errors  = 0;
        endfunction

        // Applies one accepted command to the shadow queue and records its result.
        function void note_command(logic [1:0] cmd, logic [31:0] dl, logic [31:0] tag,
                                   logic [31:0] cid);
            timer_result_t res;
            stq_entry_t    entry;
            int            k;
            res = '0;
            res.status = STATUS_OK;
            case (cmd)
                CMD_SCHEDULE: begin
                    if (timers.size() >= DEPTH) begin
                        res.status = STATUS_FULL;
                    end else begin
                        // Equal deadlines stay in arrival order.
                        k = timers.size();
                        while (k > 0 && timers[k-1].deadline > dl) k--;
                        entry.deadline = dl;
                        entry.id       = next_id;
                        entry.tag      = tag;
                        timers.insert(k, entry);
                        res.timer_id = next_id;
                        next_id      = next_id + 32'd1;
                    end
                end
                CMD_CANCEL: begin
                    res.timer_id = cid;
                    res.status   = STATUS_NOT_FOUND;
                    for (k = 0; k < timers.size(); k++) begin
                        if (timers[k].id == cid) begin
                            timers.delete(k);
                            res.status = STATUS_OK;
                            break;
                        end
                    end
                end
                CMD_FIRE: begin
                    if (timers.size() == 0) begin
                        res.status = STATUS_EMPTY;
                    end else begin
                        entry              = timers.pop_front();
                        res.timer_id       = entry.id;
                        res.fired_deadline = entry.deadline;
                        res.fired_tag      = entry.tag;
                        res.fired          = 1'b1;
                    end
                end
                default: ;
            endcase
            awaited.insert(awaited.size(), res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: result item with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("timer_id", want.timer_id, got.timer_id);
            compare_field("fired_deadline", want.fired_deadline, got.fired_deadline);
            compare_field("fired_tag", want.fired_tag, got.fired_tag);
            compare_field("fired", 32'(want.fired), 32'(got.fired));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;

    timer_scoreboard sb = new();
    timer_result_t   seen;
    bit              no_idle;
    int              items_sent;
    int              cycle_count;

    sorted_timer_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = {m_tuser[1:0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[2]};
            sb.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Presents one item after a random gap and returns at the edge that accepts it.
    task automatic send_cmd(logic [1:0] cmd, logic [31:0] dl, logic [31:0] tag,
                            logic [31:0] cid);
        int gap;
        gap = 0;
        if (!no_idle) begin
            while (gap < 12 && $urandom_range(99) < IDLE_PERCENT) gap++;
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {cid, tag, dl};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, dl, tag, cid);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
    endtask

    // Small values make equal deadlines common; the extremes turn up now and then.
    function automatic logic [31:0] pick_deadline();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($urandom_range(15));
            4:          return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            5:          return 32'hFFFF_FFF0 + 32'($urandom_range(15));
            default:    return $urandom;
        endcase
    endfunction

    // Mostly a live id, otherwise a recent id that may be gone or a random word.
    function automatic logic [31:0] pick_cancel_id();
        int r;
        r = $urandom_range(99);
        if (r < 70 && sb.timers.size() > 0)
            return sb.timers[$urandom_range(sb.timers.size() - 1)].id;
        if (r < 85)
            return sb.next_id - 32'($urandom_range(8));
        return $urandom;
    endfunction

    initial begin
        stim_phase_t mode;
        logic [1:0]  cmd;
        int          phase;
        int          plen;
        int          roll;
        int          n;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_SCHEDULE;
        m_tready = 1'b0;
        no_idle  = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty queue, unused command, extremes and a group of equal deadlines.
        send_cmd(CMD_FIRE, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_CANCEL, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_SCHEDULE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_cmd(CMD_SCHEDULE, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_cmd(CMD_SCHEDULE, 32'd100, 32'd1, 32'h0);
        send_cmd(CMD_SCHEDULE, 32'd100, 32'd2, 32'h0);
        send_cmd(CMD_SCHEDULE, 32'd100, 32'd3, 32'h0);
        send_cmd(CMD_SCHEDULE, 32'd50, 32'd4, 32'h0);
        send_cmd(CMD_CANCEL, 32'h0, 32'h0, 32'd3);
        send_cmd(CMD_CANCEL, 32'h0, 32'h0, 32'd3);
        send_cmd(CMD_CANCEL, 32'h0, 32'h0, 32'd0);
        repeat (5) send_cmd(CMD_FIRE, 32'h0, 32'h0, 32'h0);
        send_cmd(CMD_UNUSED, 32'h0, 32'h0, 32'h0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase == 0) begin
                mode = PH_FILL;
                plen = 110;
            end else begin
                mode = stim_phase_t'($urandom_range(2));
                plen = $urandom_range(30, 120);
            end
            // One long stretch with neither side idling.
            no_idle = (phase == 4);
            if (no_idle) plen = 200;
            for (n = 0; n < plen; n++) begin
                roll = $urandom_range(99);
                case (mode)
                    PH_FILL:
                        cmd = roll < 85 ? CMD_SCHEDULE : (roll < 95 ? CMD_CANCEL : CMD_FIRE);
                    PH_DRAIN:
                        cmd = roll < 65 ? CMD_FIRE : (roll < 88 ? CMD_CANCEL : CMD_SCHEDULE);
                    default:
                        cmd = roll < 45 ? CMD_SCHEDULE : (roll < 75 ? CMD_FIRE : CMD_CANCEL);
                endcase
                if ($urandom_range(99) < 2) cmd = CMD_UNUSED;
                send_cmd(cmd, pick_deadline(), $urandom, pick_cancel_id());
            end
            no_idle = 1'b0;
            if (phase == 1 || $urandom_range(3) == 0) wait_drained();
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
